[rtl/afc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package afc_pkg;

  localparam int NUM_COLUMNS = 4;
  localparam int NUM_PLANES  = 6;
  localparam int NUM_AXES    = 3;
  localparam int COL_W       = 64;
  localparam int IDX_W       = 2;
  localparam int D_SHIFT     = 4;   // Q.12 constant term aligned to the Q.16 products

  // Plane order
  localparam int PLANE_LEFT   = 0;
  localparam int PLANE_RIGHT  = 1;
  localparam int PLANE_TOP    = 2;
  localparam int PLANE_BOTTOM = 3;
  localparam int PLANE_NEAR   = 4;
  localparam int PLANE_FAR    = 5;

  // Coefficient order within a plane (also the matrix column it comes from)
  localparam int COEF_A = 0;
  localparam int COEF_B = 1;
  localparam int COEF_C = 2;
  localparam int COEF_D = 3;

  typedef logic [COL_W-1:0]   column_t;
  typedef logic signed [15:0] coord_t;   // Q11.4
  typedef logic signed [16:0] coef_t;    // Q4.12
  typedef logic signed [32:0] prod_t;    // Q16.16
  typedef logic signed [34:0] dist_t;

  typedef coef_t [NUM_PLANES-1:0] coef_set_t;

  typedef struct packed {
    coef_t d;
    coef_t c;
    coef_t b;
    coef_t a;
  } plane_t;

  typedef coord_t [NUM_AXES-1:0] box_vec_t;

  // Identity matrix column after reset
  function automatic column_t reset_column(input int col);
    return column_t'(64'h1000) << (16 * col);
  endfunction

  // One coefficient of each plane from one matrix column
  function automatic coef_set_t column_coefs(input column_t col);
    coef_t     r0;
    coef_t     r1;
    coef_t     r2;
    coef_t     r3;
    coef_set_t s;
    r0 = {col[15], col[15:0]};
    r1 = {col[31], col[31:16]};
    r2 = {col[47], col[47:32]};
    r3 = {col[63], col[63:48]};
    s[PLANE_LEFT]   = r3 + r0;
    s[PLANE_RIGHT]  = r3 - r0;
    s[PLANE_TOP]    = r3 - r1;
    s[PLANE_BOTTOM] = r3 + r1;
    s[PLANE_NEAR]   = r2;
    s[PLANE_FAR]    = r3 - r2;
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/afc_plane_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module afc_plane_regs
  import afc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire column_t          cfg_wdata,
  output plane_t                planes [NUM_PLANES]
);

  // Each column feeds one coefficient of every plane, so derive at write time
  coef_set_t coef_r [NUM_COLUMNS];

  for (genvar k = 0; k < NUM_COLUMNS; k++) begin : g_col
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coef_r[k] <= column_coefs(reset_column(k));
      end else if (cfg_we && (cfg_index == IDX_W'(k))) begin
        coef_r[k] <= column_coefs(cfg_wdata);
      end
    end
  end

  // Regroup by plane
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    assign planes[p].a = coef_r[COEF_A][p];
    assign planes[p].b = coef_r[COEF_B][p];
    assign planes[p].c = coef_r[COEF_C][p];
    assign planes[p].d = coef_r[COEF_D][p];
  end

endmodule

`default_nettype wire

[rtl/afc_plane_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module afc_plane_lane
  import afc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     en,
  input  wire box_vec_t box_lo,
  input  wire box_vec_t box_hi,
  input  wire plane_t   plane,
  output logic          cull
);

  coef_t coef   [NUM_AXES];
  prod_t prod_r [NUM_AXES];
  prod_t prod_nxt [NUM_AXES];
  dist_t distance;

  assign coef[0] = plane.a;
  assign coef[1] = plane.b;
  assign coef[2] = plane.c;

  // Pick the corner farthest along the normal and multiply per axis
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      prod_nxt[k] = prod_t'(coef[k]) *
                    prod_t'(coef[k][16] ? box_lo[k] : box_hi[k]);
    end
  end

  // Hold products while the next stage is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // Signed distance of the chosen corner; negative means outside
  assign distance = dist_t'(prod_r[0]) + dist_t'(prod_r[1]) + dist_t'(prod_r[2])
                  + (dist_t'(plane.d) <<< D_SHIFT);
  assign cull = distance[$bits(dist_t)-1];

endmodule

`default_nettype wire

[rtl/aabb_frustum_cull_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_min_x..in_max_z, Q11.4 each
// out      output     out_valid / out_stall out_visible
// cfg      input      cfg_we                cfg_index, cfg_wdata (matrix column)
//
// Three register stages: box, per-plane products, result. One item per cycle while
// out_stall is low; out_valid rises when an accepted item loads the result stage.
// The six plane lanes each hold three 17x16 multipliers; their sums feed the result.
// Reset (synchronous) empties the pipeline and loads the identity matrix.
// A stalled output holds its stage; earlier empty stages still take items.

module aabb_frustum_cull_unit
  import afc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire coord_t           in_min_x,
  input  wire coord_t           in_min_y,
  input  wire coord_t           in_min_z,
  input  wire coord_t           in_max_x,
  input  wire coord_t           in_max_y,
  input  wire coord_t           in_max_z,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_visible,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire column_t          cfg_wdata
);

  plane_t   planes [NUM_PLANES];
  box_vec_t box_lo_r;
  box_vec_t box_hi_r;
  logic     box_valid_r;
  logic     prod_valid_r;
  logic     out_valid_r;
  logic     out_visible_r;
  logic     out_ready;
  logic     prod_ready;
  logic     box_ready;
  logic [NUM_PLANES-1:0] cull;

  afc_plane_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .planes    (planes)
  );

  // Stage may load when empty or when its item moves on
  assign out_ready  = !out_valid_r || !out_stall;
  assign prod_ready = !prod_valid_r || out_ready;
  assign box_ready  = !box_valid_r || prod_ready;
  assign in_stall   = !box_ready;

  // Capture the item
  always_ff @(posedge clk) begin
    if (in_valid && box_ready) begin
      box_lo_r <= {in_min_z, in_min_y, in_min_x};
      box_hi_r <= {in_max_z, in_max_y, in_max_x};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_valid_r  <= 1'b0;
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (box_ready)  box_valid_r  <= in_valid;
      if (prod_ready) prod_valid_r <= box_valid_r;
      if (out_ready)  out_valid_r  <= prod_valid_r;
    end
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    afc_plane_lane u_lane (
      .clk    (clk),
      .en     (box_valid_r && prod_ready),
      .box_lo (box_lo_r),
      .box_hi (box_hi_r),
      .plane  (planes[p]),
      .cull   (cull[p])
    );
  end

  // Visible when no plane culls
  always_ff @(posedge clk) begin
    if (prod_valid_r && out_ready) begin
      out_visible_r <= ~|cull;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule

`default_nettype wire
